/* rtl/core/mdpc_pkg.sv */
package mdpc_pkg;

  // default pixel coordinate width
  localparam int unsigned COORD_BITS_DEF = 12;

  // field widths of the pixel request
  localparam int unsigned DepthW = 16;
  localparam int unsigned PixW   = 12;

  // configuration register map
  typedef enum logic [2:0] {
    CFG_DEPTH_THRESHOLD = 3'd0,
    CFG_INTRINSICS      = 3'd1,
    CFG_ROW_X           = 3'd2,
    CFG_ROW_Y           = 3'd3,
    CFG_ROW_Z           = 3'd4,
    CFG_BOX_X           = 3'd5,
    CFG_BOX_Y           = 3'd6,
    CFG_BOX_Z           = 3'd7
  } cfg_idx_e;

  // register reset values
  localparam logic [15:0] RST_THRESHOLD  = 16'd10;
  localparam logic [63:0] RST_INTRINSICS = 64'h0;
  localparam logic [63:0] RST_ROW_X      = 64'h0000_0000_0000_4000;
  localparam logic [63:0] RST_ROW_Y      = 64'h0000_0000_4000_0000;
  localparam logic [63:0] RST_ROW_Z      = 64'h0000_4000_0000_0000;
  localparam logic [63:0] RST_BOX        = 64'h7FFF_FFFF_8000_0000;

  typedef struct packed {
    logic [DepthW-1:0] depth_sample;
    logic [DepthW-1:0] robot_depth;
    logic [PixW-1:0]   column;
    logic [PixW-1:0]   row;
  } pixel_t;

  typedef struct packed {
    logic [DepthW-1:0] masked_depth;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               point_valid;
  } point_t;

  // usable bits of the column and row fields
  function automatic int unsigned coord_used(input int unsigned cb);
    return (cb < PixW) ? cb : PixW;
  endfunction

  // width of the signed centered pixel offset u*16 - cx
  function automatic int unsigned dx_width(input int unsigned cb);
    int unsigned w;
    w = coord_used(cb) + 4;
    return ((w > 16) ? w : 16) + 1;
  endfunction

  // width of the back-projected x and y in 1/16 mm
  function automatic int unsigned xy_width(input int unsigned cb);
    return dx_width(cb) + 10;
  endfunction

endpackage

/* rtl/core/mdpc_project.sv */
module mdpc_project #(
  parameter int unsigned COORD_BITS = mdpc_pkg::COORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  mdpc_pkg::pixel_t    pix_i,
  input  logic [15:0]         thr_i,
  input  logic [63:0]         intr_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [15:0]         d_o,
  output logic signed [mdpc_pkg::xy_width(COORD_BITS)-1:0] x_o,
  output logic signed [mdpc_pkg::xy_width(COORD_BITS)-1:0] y_o
);

  localparam int unsigned UB  = mdpc_pkg::coord_used(COORD_BITS);
  localparam int unsigned DXW = mdpc_pkg::dx_width(COORD_BITS);
  localparam int unsigned M1W = DXW + 17;
  localparam int unsigned M2W = M1W + 17;
  localparam int unsigned XW  = M2W - 24;
  localparam int unsigned NS  = 4;

  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 0: self-filter and centered pixel offsets
  logic [16:0]           diff;
  logic [15:0]           adiff;
  logic                  drop;
  logic [15:0]           d0_d, d0_q;
  logic signed [DXW-1:0] dx_d, dy_d, dx_q, dy_q;

  always_comb begin
    diff  = {1'b0, pix_i.depth_sample} - {1'b0, pix_i.robot_depth};
    adiff = diff[16] ? 16'(-diff) : diff[15:0];
    drop  = (pix_i.depth_sample != '0) && (pix_i.robot_depth != '0) && (adiff < thr_i);
    d0_d  = drop ? '0 : pix_i.depth_sample;
    dx_d  = $signed({{(DXW-UB-4){1'b0}}, pix_i.column[UB-1:0], 4'b0})
          - $signed({{(DXW-16){1'b0}}, intr_i[15:0]});
    dy_d  = $signed({{(DXW-UB-4){1'b0}}, pix_i.row[UB-1:0], 4'b0})
          - $signed({{(DXW-16){1'b0}}, intr_i[31:16]});
  end

  // stage 1: offset times depth
  logic signed [M1W-1:0] m1x_q, m1y_q;
  logic [15:0]           d1_q;

  // stage 2: times reciprocal focal length
  logic signed [M2W-1:0] m2x_q, m2y_q;
  logic [15:0]           d2_q;

  // stage 3: round to 1/16 mm
  logic signed [M2W-1:0] rx, ry;
  logic signed [XW-1:0]  x_q, y_q;
  logic [15:0]           d3_q;

  localparam logic signed [M2W-1:0] RndHalf = {{(M2W-24){1'b0}}, 1'b1, 23'b0};

  always_comb begin
    rx = m2x_q + RndHalf;
    ry = m2y_q + RndHalf;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      d0_q <= d0_d;
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (adv[1]) begin
      d1_q  <= d0_q;
      m1x_q <= M1W'(dx_q) * M1W'($signed({1'b0, d0_q}));
      m1y_q <= M1W'(dy_q) * M1W'($signed({1'b0, d0_q}));
    end
    if (adv[2]) begin
      d2_q  <= d1_q;
      m2x_q <= M2W'(m1x_q) * M2W'($signed({1'b0, intr_i[47:32]}));
      m2y_q <= M2W'(m1y_q) * M2W'($signed({1'b0, intr_i[63:48]}));
    end
    if (adv[3]) begin
      d3_q <= d2_q;
      x_q  <= rx[M2W-1:24];
      y_q  <= ry[M2W-1:24];
    end
  end

  assign d_o = d3_q;
  assign x_o = x_q;
  assign y_o = y_q;

endmodule

/* rtl/core/mdpc_row.sv */
module mdpc_row #(
  parameter int unsigned XW = mdpc_pkg::xy_width(mdpc_pkg::COORD_BITS_DEF)
) (
  input  logic                clk_i,
  input  logic [2:0]          en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic [15:0]         d_i,
  input  logic [63:0]         coef_i,
  output logic signed [31:0]  p_o
);

  localparam int unsigned PW   = XW + 16;
  localparam int unsigned ACCW = PW + 2;
  localparam int unsigned SW   = ACCW - 13;

  localparam logic signed [ACCW-1:0] RndHalf = {{(ACCW-14){1'b0}}, 1'b1, 13'b0};
  localparam logic signed [SW-1:0]   SatMax  = {{(SW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0]   SatMin  = {{(SW-31){1'b1}}, {31{1'b0}}};

  logic signed [20:0]      z;
  logic signed [PW-1:0]    px_q, py_q, pz_q;
  logic signed [ACCW-1:0]  acc_d, acc_q;
  logic signed [SW-1:0]    s;
  logic signed [31:0]      p_d, p_q;

  always_comb begin
    z     = $signed({1'b0, d_i, 4'b0});
    acc_d = $signed({{2{px_q[PW-1]}}, px_q}) + $signed({{2{py_q[PW-1]}}, py_q})
          + $signed({{2{pz_q[PW-1]}}, pz_q}) + RndHalf;
    s     = $signed({acc_q[ACCW-1], acc_q[ACCW-1:14]})
          + $signed({{(SW-20){coef_i[63]}}, coef_i[63:48], 4'b0});
    if (s > SatMax) begin
      p_d = 32'sh7FFF_FFFF;
    end else if (s < SatMin) begin
      p_d = 32'sh8000_0000;
    end else begin
      p_d = s[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      px_q <= PW'($signed(coef_i[15:0])) * PW'(x_i);
      py_q <= PW'($signed(coef_i[31:16])) * PW'(y_i);
      pz_q <= PW'($signed(coef_i[47:32])) * PW'(z);
    end
    if (en_i[1]) begin
      acc_q <= acc_d;
    end
    if (en_i[2]) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

/* rtl/core/mdpc_xform.sv */
module mdpc_xform #(
  parameter int unsigned XW = mdpc_pkg::xy_width(mdpc_pkg::COORD_BITS_DEF)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [15:0]          d_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic [63:0]          row_x_i,
  input  logic [63:0]          row_y_i,
  input  logic [63:0]          row_z_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [15:0]          d_o,
  output logic signed [31:0]   px_o,
  output logic signed [31:0]   py_o,
  output logic signed [31:0]   pz_o
);

  localparam int unsigned NS = 3;

  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;
  logic [15:0]   d_q [NS];

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // depth rides along for the output and the missing-depth test
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      d_q[0] <= d_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) begin
        d_q[k] <= d_q[k-1];
      end
    end
  end

  assign d_o = d_q[NS-1];

  mdpc_row #(.XW(XW)) u_row_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (x_i),
    .y_i   (y_i),
    .d_i   (d_i),
    .coef_i(row_x_i),
    .p_o   (px_o)
  );

  mdpc_row #(.XW(XW)) u_row_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (x_i),
    .y_i   (y_i),
    .d_i   (d_i),
    .coef_i(row_y_i),
    .p_o   (py_o)
  );

  mdpc_row #(.XW(XW)) u_row_z (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (x_i),
    .y_i   (y_i),
    .d_i   (d_i),
    .coef_i(row_z_i),
    .p_o   (pz_o)
  );

endmodule

/* rtl/core/mdpc_box.sv */
module mdpc_box (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [15:0]        d_i,
  input  logic signed [31:0] px_i,
  input  logic signed [31:0] py_i,
  input  logic signed [31:0] pz_i,
  input  logic [63:0]        box_x_i,
  input  logic [63:0]        box_y_i,
  input  logic [63:0]        box_z_i,
  output logic               valid_o,
  input  logic               stall_i,
  output mdpc_pkg::point_t   point_o
);

  logic             v_q;
  logic             adv;
  logic             keep;
  mdpc_pkg::point_t pt_d, pt_q;

  function automatic logic in_range(input logic [63:0] box, input logic signed [31:0] p);
    return (p >= $signed(box[31:0])) && (p <= $signed(box[63:32]));
  endfunction

  assign adv     = !v_q || !stall_i;
  assign ready_o = adv;
  assign valid_o = v_q;

  always_comb begin
    keep = (d_i != '0) && in_range(box_x_i, px_i) && in_range(box_y_i, py_i)
        && in_range(box_z_i, pz_i);
    pt_d.masked_depth = d_i;
    pt_d.point_x      = keep ? px_i : '0;
    pt_d.point_y      = keep ? py_i : '0;
    pt_d.point_z      = keep ? pz_i : '0;
    pt_d.point_valid  = keep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pt_q <= pt_d;
    end
  end

  assign point_o = pt_q;

endmodule

/* rtl/core/masked_depth_to_point_cloud.sv */
// masked depth to point cloud, one pixel request per clock when not stalled
//
// in channel: in_valid_i / in_stall_o with a pixel_t payload (depth, robot
// depth, column, row). a request is taken on a rising edge with valid high
// and stall low. out channel: out_valid_o / out_stall_i with a point_t
// payload (masked depth, saturated x/y/z in 1/16 mm, valid flag).
// cfg channel: cfg_valid_i / cfg_ready_o with a register index and 64-bit
// data; ready is always high. write registers only while the pipe is empty.
//
// the path from accepted request to the output register: 4 stages of
// self-filter and back-projection (two chained multiplies and a rounding
// shift), 3 stages of rigid transform (products, sum, shift and saturate),
// 1 stage of box test. throughput is one request per cycle unless stalled.
// each stage advances when it is empty or the one after it moves, so bubbles
// are squeezed out while the receiver stalls and a stalled result holds.
// reset clears all stage valid bits and loads the register defaults
// (identity transform, full-range box, threshold 10).
module masked_depth_to_point_cloud #(
  parameter int unsigned COORD_BITS = mdpc_pkg::COORD_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mdpc_pkg::pixel_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mdpc_pkg::point_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [63:0]      cfg_data_i
);

  localparam int unsigned XW = mdpc_pkg::xy_width(COORD_BITS);

  // configuration registers
  logic [15:0] thr_q;
  logic [63:0] intr_q, row_x_q, row_y_q, row_z_q, box_x_q, box_y_q, box_z_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= mdpc_pkg::RST_THRESHOLD;
      intr_q  <= mdpc_pkg::RST_INTRINSICS;
      row_x_q <= mdpc_pkg::RST_ROW_X;
      row_y_q <= mdpc_pkg::RST_ROW_Y;
      row_z_q <= mdpc_pkg::RST_ROW_Z;
      box_x_q <= mdpc_pkg::RST_BOX;
      box_y_q <= mdpc_pkg::RST_BOX;
      box_z_q <= mdpc_pkg::RST_BOX;
    end else if (cfg_valid_i) begin
      unique case (mdpc_pkg::cfg_idx_e'(cfg_index_i))
        mdpc_pkg::CFG_DEPTH_THRESHOLD: thr_q   <= cfg_data_i[15:0];
        mdpc_pkg::CFG_INTRINSICS:      intr_q  <= cfg_data_i;
        mdpc_pkg::CFG_ROW_X:           row_x_q <= cfg_data_i;
        mdpc_pkg::CFG_ROW_Y:           row_y_q <= cfg_data_i;
        mdpc_pkg::CFG_ROW_Z:           row_z_q <= cfg_data_i;
        mdpc_pkg::CFG_BOX_X:           box_x_q <= cfg_data_i;
        mdpc_pkg::CFG_BOX_Y:           box_y_q <= cfg_data_i;
        mdpc_pkg::CFG_BOX_Z:           box_z_q <= cfg_data_i;
        default:                       thr_q   <= thr_q;
      endcase
    end
  end

  // back-projection front end
  logic                 proj_ready, proj_valid;
  logic [15:0]          proj_d;
  logic signed [XW-1:0] proj_x, proj_y;

  // rigid transform, one row unit per output axis
  logic               xf_ready, xf_valid;
  logic [15:0]        xf_d;
  logic signed [31:0] xf_px, xf_py, xf_pz;

  // box test and output register
  logic box_ready;

  mdpc_project #(.COORD_BITS(COORD_BITS)) u_project (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .ready_o(proj_ready),
    .pix_i  (in_data_i),
    .thr_i  (thr_q),
    .intr_i (intr_q),
    .valid_o(proj_valid),
    .ready_i(xf_ready),
    .d_o    (proj_d),
    .x_o    (proj_x),
    .y_o    (proj_y)
  );

  assign in_stall_o = !proj_ready;

  mdpc_xform #(.XW(XW)) u_xform (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(proj_valid),
    .ready_o(xf_ready),
    .d_i    (proj_d),
    .x_i    (proj_x),
    .y_i    (proj_y),
    .row_x_i(row_x_q),
    .row_y_i(row_y_q),
    .row_z_i(row_z_q),
    .valid_o(xf_valid),
    .ready_i(box_ready),
    .d_o    (xf_d),
    .px_o   (xf_px),
    .py_o   (xf_py),
    .pz_o   (xf_pz)
  );

  mdpc_box u_box (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(xf_valid),
    .ready_o(box_ready),
    .d_i    (xf_d),
    .px_i   (xf_px),
    .py_i   (xf_py),
    .pz_i   (xf_pz),
    .box_x_i(box_x_q),
    .box_y_i(box_y_q),
    .box_z_i(box_z_q),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .point_o(out_data_o)
  );

endmodule

/* tb/mdpc_result_check.sv */
// watches the pixel, point and register channels, keeps its own copy of the
// register file and compares every point result with the oldest prediction
module mdpc_result_check #(
  parameter int unsigned COORD_BITS = mdpc_pkg::COORD_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  mdpc_pkg::pixel_t in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  mdpc_pkg::point_t out_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [63:0]      cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);
  import mdpc_pkg::*;

  localparam longint I32_MAX = 64'sh7FFF_FFFF;
  localparam longint I32_MIN = -64'sh8000_0000;

  logic [63:0] calib_q [8];
  point_t      expected_q [$];

  // floor((x + 2^(n-1)) / 2^n)
  function automatic longint round_q(input longint x, input int unsigned n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp32(input longint x);
    if (x > I32_MAX) return I32_MAX;
    if (x < I32_MIN) return I32_MIN;
    return x;
  endfunction

  // one output row: three q1.14 coefficients and a translation in mm
  function automatic longint rigid_row(input logic [63:0] rw, input longint x,
                                       input longint y, input longint z);
    longint acc;
    acc = longint'($signed(rw[15:0])) * x
        + longint'($signed(rw[31:16])) * y
        + longint'($signed(rw[47:32])) * z;
    return clamp32(round_q(acc, 14) + longint'($signed(rw[63:48])) * 16);
  endfunction

  function automatic bit box_holds(input logic [63:0] box, input longint p);
    return p >= longint'($signed(box[31:0])) && p <= longint'($signed(box[63:32]));
  endfunction

  function automatic point_t project_pixel(input pixel_t px);
    longint d, r, u, v, gap, xq, yq, zq, tx, ty, tz;
    logic [63:0] intr;
    point_t res;
    d = longint'(px.depth_sample);
    r = longint'(px.robot_depth);
    u = longint'(px.column) & ((longint'(1) << COORD_BITS) - 1);
    v = longint'(px.row) & ((longint'(1) << COORD_BITS) - 1);
    intr = calib_q[CFG_INTRINSICS];
    // robot self-filter
    if (d != 0 && r != 0) begin
      gap = (d > r) ? d - r : r - d;
      if (gap < longint'(calib_q[CFG_DEPTH_THRESHOLD][15:0])) d = 0;
    end
    res = '0;
    res.masked_depth = d[15:0];
    if (d != 0) begin
      xq = round_q((u * 16 - longint'(intr[15:0])) * d * longint'(intr[47:32]), 24);
      yq = round_q((v * 16 - longint'(intr[31:16])) * d * longint'(intr[63:48]), 24);
      zq = d * 16;
      tx = rigid_row(calib_q[CFG_ROW_X], xq, yq, zq);
      ty = rigid_row(calib_q[CFG_ROW_Y], xq, yq, zq);
      tz = rigid_row(calib_q[CFG_ROW_Z], xq, yq, zq);
      if (box_holds(calib_q[CFG_BOX_X], tx) && box_holds(calib_q[CFG_BOX_Y], ty) &&
          box_holds(calib_q[CFG_BOX_Z], tz)) begin
        res.point_x     = tx[31:0];
        res.point_y     = ty[31:0];
        res.point_z     = tz[31:0];
        res.point_valid = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    point_t want;
    if (!rst_ni) begin
      calib_q[CFG_DEPTH_THRESHOLD] = {48'd0, RST_THRESHOLD};
      calib_q[CFG_INTRINSICS]      = RST_INTRINSICS;
      calib_q[CFG_ROW_X]           = RST_ROW_X;
      calib_q[CFG_ROW_Y]           = RST_ROW_Y;
      calib_q[CFG_ROW_Z]           = RST_ROW_Z;
      calib_q[CFG_BOX_X]           = RST_BOX;
      calib_q[CFG_BOX_Y]           = RST_BOX;
      calib_q[CFG_BOX_Z]           = RST_BOX;
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("point result with no request pending: depth %0d x %0d y %0d z %0d",
                     out_data_i.masked_depth, out_data_i.point_x, out_data_i.point_y,
                     out_data_i.point_z);
        end else begin
          want = expected_q.pop_front();
          if (want.masked_depth !== out_data_i.masked_depth ||
              want.point_x !== out_data_i.point_x || want.point_y !== out_data_i.point_y ||
              want.point_z !== out_data_i.point_z ||
              want.point_valid !== out_data_i.point_valid) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"point mismatch (exp/got): depth %0d/%0d x %0d/%0d y %0d/%0d",
                        " z %0d/%0d valid %0b/%0b"},
                       want.masked_depth, out_data_i.masked_depth,
                       want.point_x, out_data_i.point_x, want.point_y, out_data_i.point_y,
                       want.point_z, out_data_i.point_z,
                       want.point_valid, out_data_i.point_valid);
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(project_pixel(in_data_i));
      if (cfg_valid_i && cfg_ready_i)
        calib_q[cfg_index_i] = (cfg_index_i == CFG_DEPTH_THRESHOLD) ?
                               {48'd0, cfg_data_i[15:0]} : cfg_data_i;
      pending_o = expected_q.size();
    end
  end

endmodule

/* tb/masked_depth_to_point_cloud_tb.sv */
// drives pixel requests and register writes into the block, a separate
// checker predicts every point; this module only makes stimulus and the verdict
module masked_depth_to_point_cloud_tb;
  import mdpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned ITEMS_PER_BURST = 210;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  pixel_t      in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  point_t      out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_DEPTH_THRESHOLD;
  logic [63:0] cfg_data  = '0;

  int          failures;
  int          pending;
  int unsigned cycles = 0;

  // idling odds in percent, changed per phase
  int unsigned send_gap_pct = 7;
  int unsigned stall_pct    = 65;

  // register setting about to be written
  logic [63:0] set_thr, set_intr, set_row_x, set_row_y, set_row_z;
  logic [63:0] set_box_x, set_box_y, set_box_z;

  masked_depth_to_point_cloud dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  mdpc_result_check result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (failures),
    .pending_o    (pending)
  );

  always #4 clk_i = ~clk_i;

  // receiver side: random stall per cycle at the current odds
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic pixel_t pix(input logic [15:0] d, input logic [15:0] r,
                                 input logic [11:0] c, input logic [11:0] w);
    pixel_t px;
    px.depth_sample = d;
    px.robot_depth  = r;
    px.column       = c;
    px.row          = w;
    return px;
  endfunction

  // mostly plausible depths, robot depth often near the sample so the
  // self-filter threshold is hit from both sides
  function automatic pixel_t random_pixel();
    pixel_t      px;
    int unsigned pick;
    int unsigned thr;
    longint      dd, rr;
    thr  = 32'(set_thr[15:0]);
    pick = $urandom_range(99);
    if (pick < 10)      dd = 0;
    else if (pick < 18) dd = 65535;
    else if (pick < 75) dd = longint'($urandom_range(8000, 200));
    else                dd = longint'($urandom_range(65535));
    pick = $urandom_range(99);
    if (pick < 30) begin
      rr = 0;
    end else if (pick < 70) begin
      rr = dd + longint'($urandom_range(2 * thr + 2)) - longint'(thr) - 1;
      if (rr < 0) rr = 0;
      if (rr > 65535) rr = 65535;
    end else begin
      rr = longint'($urandom_range(65535));
    end
    px.depth_sample = dd[15:0];
    px.robot_depth  = rr[15:0];
    px.column       = 12'($urandom_range(4095));
    px.row          = 12'($urandom_range(4095));
    return px;
  endfunction

  // a plain axis row with a random translation, or anything at all
  function automatic logic [63:0] random_row(input logic [63:0] axis);
    logic [63:0] rw;
    rw = {$urandom(), $urandom()};
    if ($urandom_range(99) < 35) rw = {rw[63:48], axis[47:0]};
    return rw;
  endfunction

  // full range, symmetric window, ordered random bounds, or raw bits
  // (raw bits give an inverted box about half the time)
  function automatic logic [63:0] random_box();
    int unsigned pick;
    logic [31:0] lo, hi, tmp;
    pick = $urandom_range(99);
    lo   = $urandom();
    hi   = $urandom();
    if (pick < 25) return RST_BOX;
    if (pick < 65) begin
      hi = 32'd1 << $urandom_range(28, 8);
      return {hi, -hi};
    end
    if (pick < 85 && $signed(lo) > $signed(hi)) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    return {hi, lo};
  endfunction

  task automatic random_setup();
    int unsigned pick;
    set_thr = {$urandom(), $urandom()};
    pick    = $urandom_range(3);
    case (pick)
      0: begin
        set_thr[15:0] = 16'd0;
      end
      1: begin
        set_thr[15:0] = 16'hFFFF;
      end
      2: begin
        set_thr[15:0] = 16'($urandom_range(200));
      end
      default: begin
      end
    endcase
    set_intr = {$urandom(), $urandom()};
    if ($urandom_range(99) < 70) begin
      // plausible camera: centre anywhere, focal length about 256 px to 4194 px
      set_intr[15:0]  = 16'($urandom_range(65535));
      set_intr[31:16] = 16'($urandom_range(65535));
      set_intr[47:32] = 16'($urandom_range(65535, 4000));
      set_intr[63:48] = 16'($urandom_range(65535, 4000));
    end
    set_row_x = random_row(RST_ROW_X);
    set_row_y = random_row(RST_ROW_Y);
    set_row_z = random_row(RST_ROW_Z);
    set_box_x = random_box();
    set_box_y = random_box();
    set_box_z = random_box();
  endtask

  // one pixel request, with a random gap before it
  task automatic send_pixel(input pixel_t px);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk_i); while (in_stall);
  endtask

  // stop sending and let every pending point come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // leaves the write channel valid so back-to-back writes keep it high
  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // registers change only with the pipe empty
  task automatic program_setup();
    wait_drained();
    write_reg(CFG_DEPTH_THRESHOLD, set_thr);
    write_reg(CFG_INTRINSICS, set_intr);
    write_reg(CFG_ROW_X, set_row_x);
    write_reg(CFG_ROW_Y, set_row_y);
    write_reg(CFG_ROW_Z, set_row_z);
    write_reg(CFG_BOX_X, set_box_x);
    write_reg(CFG_BOX_Y, set_box_y);
    write_reg(CFG_BOX_Z, set_box_z);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    set_thr = {48'd0, RST_THRESHOLD};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: zero reciprocal focal lengths, so x = y = 0 and z = 16 d
    send_pixel(pix(16'd0, 16'd0, 12'd0, 12'd0));
    send_pixel(pix(16'hFFFF, 16'd0, 12'hFFF, 12'hFFF));

    // plausible pinhole camera, threshold 10
    set_thr   = 64'd10;
    set_intr  = {16'd31957, 16'd31957, 16'd3840, 16'd5120};
    set_row_x = RST_ROW_X;
    set_row_y = RST_ROW_Y;
    set_row_z = RST_ROW_Z;
    set_box_x = RST_BOX;
    set_box_y = RST_BOX;
    set_box_z = RST_BOX;
    program_setup();
    send_pixel(pix(16'd1000, 16'd995, 12'd320, 12'd240));   // inside threshold, removed
    send_pixel(pix(16'd1000, 16'd990, 12'd320, 12'd240));   // exactly at threshold, kept
    send_pixel(pix(16'd1000, 16'd1009, 12'd100, 12'd400));  // just under above, removed
    send_pixel(pix(16'd1000, 16'd0, 12'd100, 12'd400));     // no robot at this pixel
    send_pixel(pix(16'd0, 16'd500, 12'd10, 12'd20));        // missing depth
    send_pixel(pix(16'hFFFF, 16'hFFFF, 12'd5, 12'd6));      // equal depths, removed
    send_pixel(pix(16'd500, 16'd0, 12'd0, 12'd0));
    send_pixel(pix(16'hFFFF, 16'd0, 12'hFFF, 12'hFFF));
    send_pixel(pix(16'd3000, 16'd1, 12'd2048, 12'd1024));

    // extremes: zero threshold, all-ones intrinsics, extreme coefficients
    set_thr   = 64'd0;
    set_intr  = '1;
    set_row_x = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
    set_row_y = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
    set_row_z = {16'h8000, 16'h8000, 16'h8000, 16'h8000};
    program_setup();
    send_pixel(pix(16'hFFFF, 16'hFFFF, 12'd7, 12'd9));      // zero threshold never removes
    send_pixel(pix(16'd1, 16'd1, 12'hFFF, 12'd0));
    send_pixel(pix(16'hFFFF, 16'd0, 12'd0, 12'd0));
    send_pixel(pix(16'hFFFF, 16'd0, 12'hFFF, 12'hFFF));

    // box edges: x = y = 0, z = 16 d, window pinned on z = 16000
    set_thr   = '1;
    set_intr  = '0;
    set_row_x = RST_ROW_X;
    set_row_y = RST_ROW_Y;
    set_row_z = RST_ROW_Z;
    set_box_x = '0;
    set_box_y = '0;
    set_box_z = {32'd16000, 32'd16000};
    program_setup();
    send_pixel(pix(16'd1000, 16'd0, 12'd1, 12'd2));         // on the bound, kept
    send_pixel(pix(16'd999, 16'd0, 12'd1, 12'd2));          // below, dropped
    send_pixel(pix(16'd1001, 16'd0, 12'd1, 12'd2));         // above, dropped
    send_pixel(pix(16'd1000, 16'd1, 12'd1, 12'd2));         // full threshold removes it

    // inverted z window keeps nothing
    set_box_z = {32'd15999, 32'd16001};
    program_setup();
    send_pixel(pix(16'd1000, 16'd0, 12'd1, 12'd2));
    send_pixel(pix(16'd16000, 16'd0, 12'd3, 12'd4));

    // random part: three idling modes, two register settings each
    for (int mode = 0; mode < 3; mode++) begin
      send_gap_pct = (mode == 0) ? 7 : (mode == 1) ? 65 : 0;
      stall_pct    = (mode == 0) ? 65 : (mode == 1) ? 7 : 0;
      for (int burst = 0; burst < 2; burst++) begin
        random_setup();
        program_setup();
        for (int n = 0; n < ITEMS_PER_BURST; n++) begin
          // hold off mid-burst until every pending point is out
          if (mode == 1 && burst == 0 && n == ITEMS_PER_BURST / 2) wait_drained();
          send_pixel(random_pixel());
        end
      end
    end

    wait_drained();
    repeat (12) @(posedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
